// ===== rtl/core/button_debounce_auto_repeat_top_macros.svh =====
// Assertion macros for the key debounce block.
// Used by the checker; no other dependencies.
`ifndef BUTTON_DEBOUNCE_AUTO_REPEAT_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTO_REPEAT_TOP_MACROS_SVH

// Checked only while out of reset.
`define BDAR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define BDAR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bdar_pkg.sv =====
// Shared types and constants of the key debounce block.
// No dependencies; used by bdar_repeat, bdar_shot and the top level.
`timescale 1ns / 1ps

package bdar_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int TickW    = 16;
  localparam int PulseW   = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDebounceTicks   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRepeatTicks     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFastTicks       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFastAfterPulses = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRepeatEnable    = 3'd4;

  // Values after reset.
  localparam logic [TickW-1:0]  RstDebounceTicks   = 16'd20;
  localparam logic [TickW-1:0]  RstRepeatTicks     = 16'd50;
  localparam logic [TickW-1:0]  RstFastTicks       = 16'd10;
  localparam logic [PulseW-1:0] RstFastAfterPulses = 8'd5;
  localparam logic              RstRepeatEnable    = 1'b1;

  typedef struct packed {
    logic [TickW-1:0]  debounce_ticks;
    logic [TickW-1:0]  repeat_ticks;
    logic [TickW-1:0]  fast_ticks;
    logic [PulseW-1:0] fast_after_pulses;
    logic              repeat_enable;
  } cfg_t;

endpackage

// ===== rtl/core/bdar_in_if.sv =====
// Input channel of the key debounce block: one pin sample per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface bdar_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// ===== rtl/core/bdar_out_if.sv =====
// Output channel of the key debounce block: one result word per sample.
// Depends on nothing.
`timescale 1ns / 1ps

interface bdar_out_if;
  logic valid;
  logic ready;
  logic pressed_now;
  logic repeat_pulse;
  logic single_pulse;

  modport source (output valid, output pressed_now, output repeat_pulse,
                  output single_pulse, input ready);
  modport sink   (input valid, input pressed_now, input repeat_pulse,
                  input single_pulse, output ready);
endinterface

// ===== rtl/core/bdar_repeat.sv =====
// Typematic repeat unit: hold counter, pulse counter and interval select.
// Depends on bdar_pkg.
`timescale 1ns / 1ps

module bdar_repeat #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          pressed_i,
  input  bdar_pkg::cfg_t cfg_i,
  output logic          rep_o
);

  localparam int CmpW = (COUNT_WIDTH > bdar_pkg::TickW) ? COUNT_WIDTH : bdar_pkg::TickW;

  typedef enum logic [1:0] {
    SelDebounce = 2'd0,
    SelRepeat   = 2'd1,
    SelFast     = 2'd2,
    SelNever    = 2'd3
  } sel_e;

  logic [COUNT_WIDTH-1:0]       cnt_q, cnt_d, cnt_upd;
  logic [bdar_pkg::PulseW-1:0]  pulses_q, pulses_d, pulses_upd;
  sel_e                         sel_q, sel_d, sel_upd;
  logic                         last_q;
  logic [CmpW-1:0]              cnt_ext;
  logic                         hit;

  always_comb begin
    cnt_upd    = cnt_q;
    pulses_upd = pulses_q;
    sel_upd    = sel_q;
    if (pressed_i && last_q) begin
      cnt_upd = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
    end else if (last_q) begin
      // First released tick after a press starts the next press afresh.
      cnt_upd    = '0;
      pulses_upd = '0;
      sel_upd    = SelDebounce;
    end

    cnt_ext = CmpW'(cnt_upd);
    unique case (sel_upd)
      SelDebounce: hit = (cnt_ext == CmpW'(cfg_i.debounce_ticks));
      SelRepeat:   hit = (cnt_ext == CmpW'(cfg_i.repeat_ticks));
      SelFast:     hit = (cnt_ext == CmpW'(cfg_i.fast_ticks));
      SelNever:    hit = 1'b0;
      default:     hit = 1'b0;
    endcase

    cnt_d    = cnt_upd;
    pulses_d = pulses_upd;
    sel_d    = sel_upd;
    if (hit) begin
      cnt_d = '0;
      if (pulses_upd != {bdar_pkg::PulseW{1'b1}}) begin
        pulses_d = pulses_upd + bdar_pkg::PulseW'(1);
      end
      if (cfg_i.repeat_enable) begin
        sel_d = (pulses_d < cfg_i.fast_after_pulses) ? SelRepeat : SelFast;
      end else begin
        sel_d = SelNever;
      end
    end
  end

  assign rep_o = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      pulses_q <= '0;
      sel_q    <= SelDebounce;
      last_q   <= 1'b0;
    end else if (step_i) begin
      cnt_q    <= cnt_d;
      pulses_q <= pulses_d;
      sel_q    <= sel_d;
      last_q   <= pressed_i;
    end
  end

endmodule

// ===== rtl/core/bdar_shot.sv =====
// Single-shot unit: one debounced pulse per press, gated by the block flag.
// Depends on bdar_pkg.
`timescale 1ns / 1ps

module bdar_shot #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          pressed_i,
  input  logic          rep_i,
  input  bdar_pkg::cfg_t cfg_i,
  output logic          shot_o
);

  localparam int CmpW = (COUNT_WIDTH > bdar_pkg::TickW) ? COUNT_WIDTH : bdar_pkg::TickW;

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_upd;
  logic                   last_q;
  logic                   blocked_q, blocked_d, blocked_eff;
  logic                   hit;

  always_comb begin
    cnt_upd = cnt_q;
    if (pressed_i && last_q) begin
      cnt_upd = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
    end else if (last_q) begin
      cnt_upd = '0;
    end
    hit   = (CmpW'(cnt_upd) == CmpW'(cfg_i.debounce_ticks));
    cnt_d = hit ? '0 : cnt_upd;

    // A released pin clears the block flag before the shot is judged.
    blocked_eff = pressed_i & blocked_q;
    shot_o      = hit & ~blocked_eff;
    blocked_d   = blocked_eff | shot_o | rep_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      last_q    <= 1'b0;
      blocked_q <= 1'b0;
    end else if (step_i) begin
      cnt_q     <= cnt_d;
      last_q    <= pressed_i;
      blocked_q <= blocked_d;
    end
  end

endmodule

// ===== rtl/core/button_debounce_auto_repeat_top.sv =====
// Top level of the key debounce block with typematic repeat.
// Depends on bdar_pkg, bdar_in_if, bdar_out_if, bdar_shot and bdar_repeat.
`timescale 1ns / 1ps

// Key debounce with auto repeat. Each input word is one raw sample of an
// active-low key pin; each sample yields exactly one output word holding the
// raw pressed level, a repeat pulse (first after debounce_ticks held ticks,
// then every repeat_ticks, then every fast_ticks once fast_after_pulses
// pulses are out; none after the first if repeat_enable is clear) and a
// single-shot pulse given at most once per press. A sample passes an input
// register and the counter update into a result register, so the block
// takes one word per clock while the output is not stalled. Configuration
// registers are to be written through cfg_we_i/cfg_idx_i/cfg_data_i only
// while idle; the user is bound to this, the block does not enforce it.
module button_debounce_auto_repeat_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bdar_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bdar_pkg::CfgDataW-1:0]  cfg_data_i,
  bdar_in_if.sink                        in_i,
  bdar_out_if.source                     out_o
);

  bdar_pkg::cfg_t cfg_q;

  logic in_vld_q, pin_q;
  logic out_vld_q, pressed_q, rep_q, shot_q;
  logic adv, step, pressed, rep, shot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks    <= bdar_pkg::RstDebounceTicks;
      cfg_q.repeat_ticks      <= bdar_pkg::RstRepeatTicks;
      cfg_q.fast_ticks        <= bdar_pkg::RstFastTicks;
      cfg_q.fast_after_pulses <= bdar_pkg::RstFastAfterPulses;
      cfg_q.repeat_enable     <= bdar_pkg::RstRepeatEnable;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdar_pkg::CfgDebounceTicks:   cfg_q.debounce_ticks <= cfg_data_i;
        bdar_pkg::CfgRepeatTicks:     cfg_q.repeat_ticks   <= cfg_data_i;
        bdar_pkg::CfgFastTicks:       cfg_q.fast_ticks     <= cfg_data_i;
        bdar_pkg::CfgFastAfterPulses: begin
          cfg_q.fast_after_pulses <= cfg_data_i[bdar_pkg::PulseW-1:0];
        end
        bdar_pkg::CfgRepeatEnable:    cfg_q.repeat_enable  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The result register drains or is empty, so the sample moves on.
  assign adv        = ~out_vld_q | out_o.ready;
  assign in_i.ready = ~in_vld_q | adv;
  assign step       = in_vld_q & adv;
  assign pressed    = ~pin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      pin_q <= in_i.pin_level;
    end
    if (step) begin
      pressed_q <= pressed;
      rep_q     <= rep;
      shot_q    <= shot;
    end
  end

  bdar_repeat #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_repeat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .pressed_i(pressed),
    .cfg_i    (cfg_q),
    .rep_o    (rep)
  );

  bdar_shot #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_shot (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .pressed_i(pressed),
    .rep_i    (rep),
    .cfg_i    (cfg_q),
    .shot_o   (shot)
  );

  assign out_o.valid        = out_vld_q;
  assign out_o.pressed_now  = pressed_q;
  assign out_o.repeat_pulse = rep_q;
  assign out_o.single_pulse = shot_q;

endmodule

// ===== rtl/core/bdar_checker.sv =====
// Port-level checks of the key debounce block, bound to the top level.
// Depends on button_debounce_auto_repeat_top_macros.svh.
`timescale 1ns / 1ps
`include "button_debounce_auto_repeat_top_macros.svh"

module bdar_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_pressed_now_i,
  input logic out_repeat_pulse_i,
  input logic out_single_pulse_i
);

  // Nothing can be pending right out of reset.
  `BDAR_ASSERT_ALWAYS(a_no_word_in_reset, clk_i, !rst_ni |-> !out_valid_i, "output valid in reset")

  // With the result register empty the pipeline must take a new sample.
  `BDAR_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_i |-> in_ready_i, "input stalled with empty output")

  // An accepted sample has its word on the output once it has passed the input and result registers.
  `BDAR_ASSERT(a_accept_to_output, clk_i, rst_ni, in_valid_i && in_ready_i |-> ##2 out_valid_i, "accepted word missing")

  `BDAR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "output word dropped")

  `BDAR_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_pressed_now_i) && $stable(out_repeat_pulse_i) && $stable(out_single_pulse_i), "stalled word changed")

endmodule

bind button_debounce_auto_repeat_top bdar_checker u_bdar_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_pressed_now_i (out_o.pressed_now),
  .out_repeat_pulse_i(out_o.repeat_pulse),
  .out_single_pulse_i(out_o.single_pulse)
);
